@@ rtl/mmm_pkg.sv @@
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared widths, register indexes and the configuration bundle of the
// Montgomery multiplier.
// ----------------------------------------------------------------------------
package mmm_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int BITS_W  = 7;
    localparam int ADDR_W  = 5;
    localparam int NSTAGE  = 9;

    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_BITS     = 2'd1;
    localparam logic [1:0] REG_NPRIME   = 2'd2;
    localparam logic [1:0] REG_RSQUARED = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] modulus;
        logic [WORD_W-1:0] n_prime;
        logic [WORD_W-1:0] mask;
        logic [BITS_W-1:0] k;
    } mmm_cfg_t;

endpackage

@@ rtl/mmm_cell.sv @@
// ----------------------------------------------------------------------------
// mmm_cell
// One Montgomery product cell: z = x*y/R mod N with one conditional
// subtraction, nine registered stages with per-stage flow control.
// ----------------------------------------------------------------------------
module mmm_cell #(
    parameter int SB_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mmm_pkg::mmm_cfg_t         cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [mmm_pkg::WORD_W-1:0] x,
    input  logic [mmm_pkg::WORD_W-1:0] y,
    input  logic [SB_W-1:0]           in_sb,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mmm_pkg::WORD_W-1:0] z,
    output logic [SB_W-1:0]           out_sb
);
    localparam int W  = mmm_pkg::WORD_W;
    localparam int H  = mmm_pkg::HALF_W;
    localparam int P  = mmm_pkg::PROD_W;
    localparam int S  = mmm_pkg::SUM_W;
    localparam int NS = mmm_pkg::NSTAGE;

    logic [NS-1:0]   v_reg;
    logic [NS:0]     en;
    logic [SB_W-1:0] sb_reg [NS];

    logic [W-1:0] pab_reg [4];
    logic [P-1:0] tf1_reg, tf2_reg, tf3_reg, tf4_reg, tf5_reg;
    logic [W-1:0] pm0_reg;
    logic [H-1:0] pm1_reg, pm2_reg;
    logic [W-1:0] m_reg;
    logic [W-1:0] pmn_reg [4];
    logic [P-1:0] mn_reg;
    logic [S-1:0] s_reg, t_reg;
    logic [W-1:0] z_reg;

    logic [W-1:0] m_next;
    logic         ge;

    assign en[NS] = out_ready;
    for (genvar i = 0; i < NS; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign z         = z_reg;
    assign out_sb    = sb_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) sb_reg[0] <= in_sb;
        for (int i = 1; i < NS; i++) begin
            if (en[i]) sb_reg[i] <= sb_reg[i-1];
        end
    end

    assign m_next = (pm0_reg + {pm1_reg + pm2_reg, {H{1'b0}}}) & cfg.mask;
    assign ge     = (t_reg[S-1:W] != '0) || (t_reg[W-1:0] >= cfg.modulus);

    always_ff @(posedge aclk) begin
        // a*b partial products
        if (en[0]) begin
            pab_reg[0] <= x[H-1:0] * y[H-1:0];
            pab_reg[1] <= x[H-1:0] * y[W-1:H];
            pab_reg[2] <= x[W-1:H] * y[H-1:0];
            pab_reg[3] <= x[W-1:H] * y[W-1:H];
        end
        if (en[1]) begin
            tf1_reg <= {{W{1'b0}}, pab_reg[0]} + ({{W{1'b0}}, pab_reg[1]} << H)
                     + ({{W{1'b0}}, pab_reg[2]} << H) + {pab_reg[3], {W{1'b0}}};
        end
        // m = (t mod R) * n' mod R
        if (en[2]) begin
            tf2_reg <= tf1_reg;
            pm0_reg <= tf1_reg[H-1:0] * cfg.n_prime[H-1:0];
        end
        if (en[2]) begin
            pm1_reg <= H'(tf1_reg[H-1:0] * cfg.n_prime[W-1:H]);
            pm2_reg <= H'(tf1_reg[W-1:H] * cfg.n_prime[H-1:0]);
        end
        if (en[3]) begin
            tf3_reg <= tf2_reg;
            m_reg   <= m_next;
        end
        // m*N partial products
        if (en[4]) begin
            tf4_reg    <= tf3_reg;
            pmn_reg[0] <= m_reg[H-1:0] * cfg.modulus[H-1:0];
            pmn_reg[1] <= m_reg[H-1:0] * cfg.modulus[W-1:H];
            pmn_reg[2] <= m_reg[W-1:H] * cfg.modulus[H-1:0];
            pmn_reg[3] <= m_reg[W-1:H] * cfg.modulus[W-1:H];
        end
        if (en[5]) begin
            tf5_reg <= tf4_reg;
            mn_reg  <= {{W{1'b0}}, pmn_reg[0]} + ({{W{1'b0}}, pmn_reg[1]} << H)
                     + ({{W{1'b0}}, pmn_reg[2]} << H) + {pmn_reg[3], {W{1'b0}}};
        end
        if (en[6]) s_reg <= {1'b0, tf5_reg} + {1'b0, mn_reg};
        if (en[7]) t_reg <= s_reg >> cfg.k;
        if (en[8]) z_reg <= ge ? (t_reg[W-1:0] - cfg.modulus) : t_reg[W-1:0];
    end

endmodule

@@ rtl/montgomery_modular_multiplier_top.sv @@
// ----------------------------------------------------------------------------
// montgomery_modular_multiplier_top
// Montgomery / plain modular multiplier built from a chain of product cells.
//
//  channel  dir  handshake          contents
//  s_       in   tvalid/tready      tdata operands, tuser op
//  m_       out  tvalid/tready      tdata product
//  apb      in   psel/penable       modulus, bits, n', R^2 mod N
//
// one beat per cycle while m_tready allows; a beat passes three cells of nine stages in series
// m_tready back-pressure sets the pace, every stage holds one beat
// each stage advances when empty or when the next one moves
// aresetn clears all valid bits and restores the register defaults
// ----------------------------------------------------------------------------
module montgomery_modular_multiplier_top #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*mmm_pkg::WORD_W-1:0]  s_tdata,   // operand_a, operand_b
    input  logic                          s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mmm_pkg::WORD_W-1:0]    m_tdata,   // product
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mmm_pkg::ADDR_W-1:0]    paddr,
    input  logic [mmm_pkg::WORD_W-1:0]    pwdata,
    output logic [mmm_pkg::WORD_W-1:0]    prdata,
    output logic                          pready
);
    localparam int W  = mmm_pkg::WORD_W;
    localparam int KB = mmm_pkg::BITS_W;

    logic [W-1:0]  modulus_reg, n_prime_reg, r_squared_reg;
    logic [KB-1:0] bits_reg, k_eff;
    logic [1:0]    idx;
    mmm_pkg::mmm_cfg_t cfg;

    assign pready = 1'b1;
    assign idx    = paddr[mmm_pkg::ADDR_W-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= W'(3);
            bits_reg      <= KB'(2);
            n_prime_reg   <= W'(1);
            r_squared_reg <= W'(1);
        end else if (psel && penable && pwrite) begin
            case (idx)
                mmm_pkg::REG_MODULUS:  modulus_reg   <= pwdata;
                mmm_pkg::REG_BITS:     bits_reg      <= pwdata[KB-1:0];
                mmm_pkg::REG_NPRIME:   n_prime_reg   <= pwdata;
                mmm_pkg::REG_RSQUARED: r_squared_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            mmm_pkg::REG_MODULUS:  prdata = modulus_reg;
            mmm_pkg::REG_BITS:     prdata = {{(W-KB){1'b0}}, bits_reg};
            mmm_pkg::REG_NPRIME:   prdata = n_prime_reg;
            mmm_pkg::REG_RSQUARED: prdata = r_squared_reg;
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        if (bits_reg < KB'(2))              k_eff = KB'(2);
        else if (bits_reg > KB'(MAX_WIDTH)) k_eff = KB'(MAX_WIDTH);
        else                                k_eff = bits_reg;
    end

    assign cfg.modulus = modulus_reg;
    assign cfg.n_prime = n_prime_reg;
    assign cfg.k       = k_eff;
    assign cfg.mask    = (k_eff >= KB'(W)) ? {W{1'b1}} : ((W'(1) << k_eff) - W'(1));

    logic [W-1:0] opa, opb, ya, pa, pb, pc, x2;
    logic         op;
    logic         a_rdy, b_rdy, a_vld, b_vld, a_sb, b_sb;
    logic         c_rdy, c_vld, d_rdy;
    logic [W:0]   c_sb, d_sb;

    assign opa = s_tdata[W-1:0];
    assign opb = s_tdata[2*W-1:W];
    assign op  = s_tuser;
    assign ya  = op ? r_squared_reg : opb;

    // lane a: mont(a,b) or mont(a,R^2); lane b: mont(b,R^2)
    mmm_cell #(.SB_W(1)) u_cell_a (
        .aclk, .aresetn, .cfg,
        .in_valid(s_tvalid && b_rdy), .in_ready(a_rdy),
        .x(opa), .y(ya), .in_sb(op),
        .out_valid(a_vld), .out_ready(c_rdy),
        .z(pa), .out_sb(a_sb)
    );

    mmm_cell #(.SB_W(1)) u_cell_b (
        .aclk, .aresetn, .cfg,
        .in_valid(s_tvalid && a_rdy), .in_ready(b_rdy),
        .x(opb), .y(r_squared_reg), .in_sb(op),
        .out_valid(b_vld), .out_ready(c_rdy),
        .z(pb), .out_sb(b_sb)
    );

    assign s_tready = a_rdy && b_rdy;

    mmm_cell #(.SB_W(W+1)) u_cell_c (
        .aclk, .aresetn, .cfg,
        .in_valid(a_vld && b_vld), .in_ready(c_rdy),
        .x(pa), .y(pb), .in_sb({a_sb, pa}),
        .out_valid(c_vld), .out_ready(d_rdy),
        .z(pc), .out_sb(c_sb)
    );

    assign x2 = c_sb[W] ? pc : c_sb[W-1:0];

    logic [W-1:0] pd;

    mmm_cell #(.SB_W(W+1)) u_cell_d (
        .aclk, .aresetn, .cfg,
        .in_valid(c_vld), .in_ready(d_rdy),
        .x(x2), .y(W'(1)), .in_sb({c_sb[W], x2}),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .z(pd), .out_sb(d_sb)
    );

    assign m_tdata = d_sb[W] ? pd : d_sb[W-1:0];

    a_lanes_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        a_vld == b_vld) else $error("first cell lanes out of step");

    a_lanes_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        a_rdy == b_rdy) else $error("first cell lanes disagree on ready");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output moves");

    a_op_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_vld && b_vld) |-> (a_sb == b_sb))
        else $error("op tags of first cell lanes differ");

endmodule
